// ===== rtl/rgbhsv_pkg.sv =====
// Shared types and constants for the RGB to HSV pixel converter.
package rgbhsv_pkg;

    localparam int CHAN_W   = 8;   // width of one color channel
    localparam int HUE_W    = 9;   // hue in whole degrees
    localparam int FIX_W    = 15;  // saturation and value, 8 fraction bits
    localparam int HNUM_W   = 17;  // hue dividend, at most 420 * 255
    localparam int SNUM_W   = 23;  // saturation dividend, diff * 25600
    localparam int HUE_Q_W  = 9;   // hue quotient bits, quotient is at most 420
    localparam int SAT_Q_W  = 15;  // saturation quotient bits, at most 25600

    // Input register, setup stage, one stage per quotient bit, output register.
    localparam int NUM_STAGES = SAT_Q_W + 3;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    localparam logic [HUE_W-1:0] HUE_WRAP = 9'd360;

    // Which channel holds the maximum, in priority order.
    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

    // Stage after the max/min search.
    typedef struct packed {
        logic [CHAN_W-1:0] mx;
        logic [CHAN_W-1:0] mn;
        logic [1:0]        sel;
        logic [CHAN_W-1:0] p;
        logic [CHAN_W-1:0] q;
    } front_t;

    // Divider stage: partial remainders and quotients for hue and saturation.
    // The hue divides by diff, the saturation by mx.
    typedef struct packed {
        logic               gray;
        logic               black;
        logic [CHAN_W-1:0]  diff;
        logic [CHAN_W-1:0]  mx;
        logic [HNUM_W-1:0]  hrem;
        logic [HUE_Q_W-1:0] hq;
        logic [SNUM_W-1:0]  srem;
        logic [SAT_Q_W-1:0] sq;
        logic [FIX_W-1:0]   val;
    } div_t;

    typedef struct packed {
        logic [FIX_W-1:0] brightness;
        logic [FIX_W-1:0] saturation;
        logic [HUE_W-1:0] hue;
    } result_t;

endpackage

// ===== rtl/rgb_to_hsv_pixel_top.sv =====
// Top level of the RGB to HSV pixel converter, a fully pipelined datapath.
//
// Usage: one pixel enters per transaction on the s_ channel (s_tvalid, s_tready,
// s_tdata with red, green and blue) and one result leaves per transaction on the
// m_ channel (hue, saturation and value in m_tdata). Results come out in order.
// The pipeline holds 18 register stages: one input register, one setup stage
// that forms the dividends, fifteen restoring-division stages (one quotient bit
// each, set by the 15-bit saturation quotient) and one output register. Throughput
// is one pixel per clock while m_tready stays high. Each stage has its own
// valid bit and moves when it is empty or when the stage after it moves, so a
// stall on m_tready holds every full stage and still lets empty stages fill;
// s_tready drops only once the whole pipeline is full. Nothing is lost or
// repeated across a stall. Reset (rst_n low, asynchronous) empties the
// pipeline: all valid bits clear and m_tvalid is low until the first result
// arrives. The block has no configuration and keeps no state between pixels.
module rgb_to_hsv_pixel_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0 up: red[7:0], green[15:8], blue[23:16].
    input  logic [rgbhsv_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0 up: hue[8:0], saturation[23:9], brightness[38:24],
    // bit 39 is zero.
    output logic [rgbhsv_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int NS = rgbhsv_pkg::NUM_STAGES;
    localparam int ND = rgbhsv_pkg::SAT_Q_W;

    logic [NS-1:0] v_reg;
    logic [NS:0]   stage_ready;

    // A stage may load when it is empty or when its content moves on.
    assign stage_ready[NS] = m_tready;
    genvar gi;
    generate
        for (gi = 0; gi < NS; gi++)
        begin : g_ready
            assign stage_ready[gi] = !v_reg[gi] || stage_ready[gi+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (stage_ready[0])
            begin
                v_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (stage_ready[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign s_tready = stage_ready[0];

    // ------------------------------------------------------------------
    // Stage A: max, min and the branch that supplies the hue difference.
    // ------------------------------------------------------------------
    logic [rgbhsv_pkg::CHAN_W-1:0] in_red, in_green, in_blue;
    logic [rgbhsv_pkg::CHAN_W-1:0] rg_max, rg_min;
    rgbhsv_pkg::front_t front_next, front_reg;

    assign in_red   = s_tdata[7:0];
    assign in_green = s_tdata[15:8];
    assign in_blue  = s_tdata[23:16];

    always_comb
    begin
        rg_max = (in_red > in_green) ? in_red : in_green;
        rg_min = (in_red < in_green) ? in_red : in_green;
        front_next.mx = (rg_max > in_blue) ? rg_max : in_blue;
        front_next.mn = (rg_min < in_blue) ? rg_min : in_blue;
        // Ties go to red first, then green.
        priority if (front_next.mx == in_red)
        begin
            front_next.sel = rgbhsv_pkg::SEL_RED;
            front_next.p   = in_green;
            front_next.q   = in_blue;
        end
        else if (front_next.mx == in_green)
        begin
            front_next.sel = rgbhsv_pkg::SEL_GREEN;
            front_next.p   = in_blue;
            front_next.q   = in_red;
        end
        else
        begin
            front_next.sel = rgbhsv_pkg::SEL_BLUE;
            front_next.p   = in_red;
            front_next.q   = in_green;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            front_reg <= front_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: dividends for hue and saturation, and the value, which divides
    // by the constant 255 with the usual add-and-shift identity.
    // ------------------------------------------------------------------
    rgbhsv_pkg::div_t dv_reg  [0:ND];
    rgbhsv_pkg::div_t dv_next [0:ND];

    logic [7:0]  b_diff;
    logic [8:0]  b_dp;
    logic [17:0] b_dpx, b_dx, b_base, b_t60, b_tsum;
    logic [14:0] b_y, b_dy;
    logic [15:0] b_ycorr;

    always_comb
    begin
        b_diff = front_reg.mx - front_reg.mn;
        b_dp   = {1'b0, front_reg.p} - {1'b0, front_reg.q};
        b_dpx  = {{9{b_dp[8]}}, b_dp};
        b_dx   = {10'b0, b_diff};
        // 60 * (p - q), signed, as 64x - 4x.
        b_t60  = (b_dpx << 6) - (b_dpx << 2);
        unique case (front_reg.sel)
            rgbhsv_pkg::SEL_RED:   b_base = (b_dx << 8) + (b_dx << 6) + (b_dx << 5)
                                            + (b_dx << 3);
            rgbhsv_pkg::SEL_GREEN: b_base = (b_dx << 7) - (b_dx << 3);
            default:               b_base = (b_dx << 8) - (b_dx << 4);
        endcase
        // The sum is never negative and stays below 2^17.
        b_tsum = b_t60 + b_base;

        // Value: y = 100 * max, then y + floor(y / 255).
        b_y     = ({7'b0, front_reg.mx} << 6) + ({7'b0, front_reg.mx} << 5)
                  + ({7'b0, front_reg.mx} << 2);
        b_ycorr = {1'b0, b_y} + {9'b0, b_y[14:8]} + 16'd1;
        b_dy    = ({7'b0, b_diff} << 6) + ({7'b0, b_diff} << 5) + ({7'b0, b_diff} << 2);

        dv_next[0].gray  = (b_diff == '0);
        dv_next[0].black = (front_reg.mx == '0);
        dv_next[0].diff  = b_diff;
        dv_next[0].mx    = front_reg.mx;
        dv_next[0].hrem  = b_tsum[rgbhsv_pkg::HNUM_W-1:0];
        dv_next[0].hq    = '0;
        dv_next[0].srem  = {b_dy, 8'b0};
        dv_next[0].sq    = '0;
        dv_next[0].val   = b_y + {7'b0, b_ycorr[15:8]};
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[1])
        begin
            dv_reg[0] <= dv_next[0];
        end
    end

    // ------------------------------------------------------------------
    // Restoring division, one quotient bit per stage, most significant first.
    // The hue quotient finishes in the first nine stages and then rides along.
    // ------------------------------------------------------------------
    genvar gk;
    generate
        for (gk = 0; gk < ND; gk++)
        begin : g_div
            localparam int SB = ND - 1 - gk;
            logic [rgbhsv_pkg::SNUM_W-1:0] s_sub;

            assign s_sub = {{(rgbhsv_pkg::SNUM_W-rgbhsv_pkg::CHAN_W){1'b0}},
                            dv_reg[gk].mx} << SB;

            if (gk < rgbhsv_pkg::HUE_Q_W)
            begin : g_hue
                localparam int HB = rgbhsv_pkg::HUE_Q_W - 1 - gk;
                logic [rgbhsv_pkg::HNUM_W-1:0] h_sub;

                assign h_sub = {{(rgbhsv_pkg::HNUM_W-rgbhsv_pkg::CHAN_W){1'b0}},
                                dv_reg[gk].diff} << HB;

                always_comb
                begin
                    dv_next[gk+1] = dv_reg[gk];
                    if (dv_reg[gk].srem >= s_sub)
                    begin
                        dv_next[gk+1].srem   = dv_reg[gk].srem - s_sub;
                        dv_next[gk+1].sq[SB] = 1'b1;
                    end
                    if (dv_reg[gk].hrem >= h_sub)
                    begin
                        dv_next[gk+1].hrem   = dv_reg[gk].hrem - h_sub;
                        dv_next[gk+1].hq[HB] = 1'b1;
                    end
                end
            end
            else
            begin : g_sat
                always_comb
                begin
                    dv_next[gk+1] = dv_reg[gk];
                    if (dv_reg[gk].srem >= s_sub)
                    begin
                        dv_next[gk+1].srem   = dv_reg[gk].srem - s_sub;
                        dv_next[gk+1].sq[SB] = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_ready[gk+2])
                begin
                    dv_reg[gk+1] <= dv_next[gk+1];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Output register: wrap the hue into 0..359 and apply the gray and black
    // special cases, where the divisor was zero.
    // ------------------------------------------------------------------
    rgbhsv_pkg::result_t res_next, res_reg;

    always_comb
    begin
        if (dv_reg[ND].gray)
        begin
            res_next.hue = '0;
        end
        else if (dv_reg[ND].hq >= rgbhsv_pkg::HUE_WRAP)
        begin
            res_next.hue = dv_reg[ND].hq - rgbhsv_pkg::HUE_WRAP;
        end
        else
        begin
            res_next.hue = dv_reg[ND].hq;
        end
        res_next.saturation = dv_reg[ND].black ? '0 : dv_reg[ND].sq;
        res_next.brightness = dv_reg[ND].val;
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[NS-1])
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = v_reg[NS-1];
    assign m_tdata  = {1'b0, res_reg};

`ifndef SYNTHESIS
    // A receiver that is ready can never block the sender.
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("s_tready low while m_tready is high");

    // An item in the first stage that may move is found in the second stage.
    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[0] && stage_ready[1]) |=> v_reg[1])
        else $error("item dropped between the first two stages");

    // A black pixel has zero hue and zero saturation.
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[38:24] == '0) |-> (m_tdata[23:0] == '0))
        else $error("black pixel with nonzero hue or saturation");
`endif

endmodule
